FILE: src/swarq_pkg.sv
// Shared types and codes for the sliding-window ARQ sender.
// No dependencies. Imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package swarq_pkg;

	localparam logic [1:0] KIND_SEND    = 2'd0;
	localparam logic [1:0] KIND_REPLY   = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	localparam logic [1:0] REPLY_DATA = 2'd0;
	localparam logic [1:0] REPLY_ACK  = 2'd1;
	localparam logic [1:0] REPLY_NAK  = 2'd2;

	localparam logic [3:0] WINDOW_SIZE_RESET = 4'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  frame_tag;
		logic [31:0] frame_seq;
		logic [11:0] frame_size;
		logic [1:0]  reply_kind;
		logic [31:0] reply_number;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  tx_tag;
		logic [31:0] tx_seq;
		logic [11:0] tx_size;
		logic        rejected;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT_REJ,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_REFILL_CHK,
		ST_REFILL_EMIT
	} state_t;

	typedef enum logic [1:0] {
		EM_REJ,
		EM_WIN,
		EM_WAIT
	} emit_sel_t;

	typedef struct packed {
		logic      load_in;
		logic      push_wait;
		logic      walk_clr;
		logic      walk_inc;
		logic      retire;
		logic      refill_move;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] reply_kind;
		logic       wait_full;
		logic       win_empty;
		logic       walk_end;
		logic       walk_final;
		logic       match;
		logic       refill_ok;
		logic       refill_more;
		logic       out_busy;
	} sts_t;

endpackage

`default_nettype wire

FILE: src/sliding_window_arq_sender_unit.sv
// Top level of the sliding-window ARQ sender: controller plus datapath.
// Depends on swarq_pkg, swarq_ctrl and swarq_dp.
//
// Usage: events (send, reply, timeout) arrive as requests on the in channel
// (in_valid/in_ready, payload in_data). Each event gives zero to several
// transmit requests on the out channel (out_valid/out_ready, out_data); the
// final one of an event carries last. A full wait FIFO turns a send into one
// request with rejected set. The window size register is written with cfg_we
// and cfg_wdata; write it only while the block is idle, as the block itself
// does not enforce this. Each event is accepted and then decoded. A reply to
// an empty window or an unknown event ends there; a rejected send ends with its
// one request. An ack, nak or timeout walks the window entries; after that,
// as after an accepted send or a data reply, refill checks move frames from
// the wait FIFO into the window while it has room. A new event is taken once
// the controller is back in idle. Reset clears all counters and pointers,
// empties both stores and sets the window size to 4. When the receiver stalls
// the output register holds its request and the controller waits in place;
// nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_arq_sender_unit #(
	parameter int WINDOW_MAX = 8,
	parameter int WAIT_DEPTH = 16,
	parameter int TAG_BITS   = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire swarq_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output swarq_pkg::out_item_t      out_data,
	input  wire logic                 cfg_we,
	input  wire logic [3:0]           cfg_wdata
);
	import swarq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	swarq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swarq_dp #(
		.WINDOW_MAX (WINDOW_MAX),
		.WAIT_DEPTH (WAIT_DEPTH),
		.TAG_BITS   (TAG_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

FILE: src/swarq_dp.sv
// Datapath of the ARQ sender: wait FIFO memory, window memory, counters,
// walk index and output register. Depends on swarq_pkg; driven by swarq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module swarq_dp #(
	parameter int WINDOW_MAX = 8,
	parameter int WAIT_DEPTH = 16,
	parameter int TAG_BITS   = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire swarq_pkg::in_item_t  in_data,
	input  wire logic                 cfg_we,
	input  wire logic [3:0]           cfg_wdata,
	input  wire swarq_pkg::cmd_t      cmd,
	output swarq_pkg::sts_t           sts,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output swarq_pkg::out_item_t      out_data
);
	import swarq_pkg::*;

	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int WI = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int DW = $clog2(WAIT_DEPTH + 1);
	localparam int DI = $clog2(WAIT_DEPTH);
	localparam int XW = (CW > 4) ? CW : 4;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [31:0]         seq;
		logic [11:0]         size;
	} slot_t;

	function automatic logic [WI-1:0] win_wrap(input logic [CW:0] s);
		if (s >= (CW+1)'(WINDOW_MAX))
			return WI'(s - (CW+1)'(WINDOW_MAX));
		return WI'(s);
	endfunction

	function automatic logic [DI-1:0] wait_wrap(input logic [DW:0] s);
		if (s >= (DW+1)'(WAIT_DEPTH))
			return DI'(s - (DW+1)'(WAIT_DEPTH));
		return DI'(s);
	endfunction

	slot_t           wait_mem [WAIT_DEPTH];
	slot_t           win_mem  [WINDOW_MAX];
	slot_t           wait_rd_q;
	slot_t           win_rd_q;
	in_item_t        in_q;
	logic [DI-1:0]   wait_head_q;
	logic [DW-1:0]   wait_count_q;
	logic [WI-1:0]   win_head_q;
	logic [CW-1:0]   win_count_q;
	logic [CW-1:0]   idx_q;
	logic [3:0]      cfg_q;
	out_item_t       out_q;
	logic            out_valid_q;

	slot_t           in_slot;
	slot_t           em_slot;
	logic [WI-1:0]   win_rd_addr;
	logic [WI-1:0]   win_wr_addr;
	logic [DI-1:0]   wait_wr_addr;
	logic [XW-1:0]   cfg_x;
	logic [CW-1:0]   eff_w;

	always_comb begin
		in_slot.tag  = TAG_BITS'(in_q.frame_tag);
		in_slot.seq  = in_q.frame_seq;
		in_slot.size = in_q.frame_size;

		win_rd_addr  = win_wrap((CW+1)'(win_head_q) + (CW+1)'(idx_q));
		win_wr_addr  = win_wrap((CW+1)'(win_head_q) + (CW+1)'(win_count_q));
		wait_wr_addr = wait_wrap((DW+1)'(wait_head_q) + (DW+1)'(wait_count_q));

		// A zero size behaves as one and an oversized one is clipped to the store.
		cfg_x = XW'(cfg_q);
		if (cfg_q == 4'd0)
			eff_w = CW'(1);
		else if (cfg_x > XW'(WINDOW_MAX))
			eff_w = CW'(WINDOW_MAX);
		else
			eff_w = CW'(cfg_x);

		case (cmd.emit_sel)
			EM_REJ:  em_slot = in_slot;
			EM_WIN:  em_slot = win_rd_q;
			EM_WAIT: em_slot = wait_rd_q;
			default: em_slot = wait_rd_q;
		endcase

		sts.kind        = in_q.kind;
		sts.reply_kind  = in_q.reply_kind;
		sts.wait_full   = (wait_count_q == DW'(WAIT_DEPTH));
		sts.win_empty   = (win_count_q == '0);
		sts.walk_end    = (idx_q >= win_count_q);
		sts.walk_final  = ((CW+1)'(idx_q) + (CW+1)'(1) == (CW+1)'(win_count_q));
		sts.match       = (win_rd_q.seq == in_q.reply_number);
		sts.refill_ok   = (win_count_q < eff_w) && (wait_count_q != '0);
		sts.refill_more = ((CW+1)'(win_count_q) + (CW+1)'(1) < (CW+1)'(eff_w))
		                  && (wait_count_q > DW'(1));
		sts.out_busy    = out_valid_q && !out_ready;
	end

	// Memories: registered reads at the current head and walk position.
	always_ff @(posedge clk) begin
		wait_rd_q <= wait_mem[wait_head_q];
		win_rd_q  <= win_mem[win_rd_addr];
		if (cmd.push_wait)
			wait_mem[wait_wr_addr] <= in_slot;
		if (cmd.refill_move)
			win_mem[win_wr_addr] <= wait_rd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			in_q <= in_data;
		if (cmd.emit) begin
			out_q.tx_tag   <= 8'(em_slot.tag);
			out_q.tx_seq   <= em_slot.seq;
			out_q.tx_size  <= em_slot.size;
			out_q.rejected <= (cmd.emit_sel == EM_REJ);
			out_q.last     <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_head_q  <= '0;
			wait_count_q <= '0;
			win_head_q   <= '0;
			win_count_q  <= '0;
			idx_q        <= '0;
			cfg_q        <= WINDOW_SIZE_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				cfg_q <= cfg_wdata;
			if (cmd.push_wait)
				wait_count_q <= wait_count_q + DW'(1);
			if (cmd.walk_clr)
				idx_q <= '0;
			else if (cmd.walk_inc)
				idx_q <= idx_q + CW'(1);
			if (cmd.retire) begin
				win_head_q  <= win_wrap((CW+1)'(win_head_q) + (CW+1)'(idx_q) + (CW+1)'(1));
				win_count_q <= win_count_q - idx_q - CW'(1);
			end
			if (cmd.refill_move) begin
				wait_head_q  <= wait_wrap((DW+1)'(wait_head_q) + (DW+1)'(1));
				wait_count_q <= wait_count_q - DW'(1);
				win_count_q  <= win_count_q + CW'(1);
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: src/swarq_ctrl.sv
// Controller state machine of the ARQ sender: decodes each event and
// sequences window walks and refills. Depends on swarq_pkg; drives swarq_dp.
`timescale 1ns / 1ps
`default_nettype none

module swarq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire swarq_pkg::sts_t sts,
	output swarq_pkg::cmd_t      cmd
);
	import swarq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.emit_sel = EM_WAIT;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.kind)
					KIND_SEND: begin
						if (sts.wait_full) begin
							state_d = ST_EMIT_REJ;
						end else begin
							cmd.push_wait = 1'b1;
							state_d = ST_REFILL_CHK;
						end
					end
					KIND_REPLY: begin
						if (sts.win_empty) begin
							state_d = ST_IDLE;
						end else if (sts.reply_kind == REPLY_ACK ||
						             sts.reply_kind == REPLY_NAK) begin
							cmd.walk_clr = 1'b1;
							state_d = ST_WALK_RD;
						end else begin
							state_d = ST_REFILL_CHK;
						end
					end
					KIND_TIMEOUT: begin
						cmd.walk_clr = 1'b1;
						state_d = ST_WALK_RD;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_EMIT_REJ: begin
				cmd.emit_sel = EM_REJ;
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WALK_RD: begin
				if (sts.walk_end)
					state_d = ST_REFILL_CHK;
				else
					state_d = ST_WALK_CHK;
			end
			ST_WALK_CHK: begin
				cmd.emit_sel = EM_WIN;
				if (sts.kind == KIND_TIMEOUT) begin
					// Every outstanding frame goes out again, oldest first.
					if (!sts.out_busy) begin
						cmd.emit = 1'b1;
						cmd.emit_last = sts.walk_final && !sts.refill_ok;
						cmd.walk_inc = 1'b1;
						state_d = ST_WALK_RD;
					end
				end else if (!sts.match) begin
					cmd.walk_inc = 1'b1;
					state_d = ST_WALK_RD;
				end else if (sts.reply_kind == REPLY_ACK) begin
					cmd.retire = 1'b1;
					state_d = ST_REFILL_CHK;
				end else if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_last = !sts.refill_ok;
					state_d = ST_REFILL_CHK;
				end
			end
			ST_REFILL_CHK: begin
				if (sts.refill_ok)
					state_d = ST_REFILL_EMIT;
				else
					state_d = ST_IDLE;
			end
			ST_REFILL_EMIT: begin
				cmd.emit_sel = EM_WAIT;
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_last = !sts.refill_more;
					cmd.refill_move = 1'b1;
					state_d = ST_REFILL_CHK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire
